@@ hw/rtl/mat_pkg.sv @@
package mat_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_HALF   = 15;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_OFFSET  = 8'd3;

    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;
    localparam int RST_HALF   = 7;
    localparam logic signed [8:0] RST_OFFSET = 9'sd10;

    localparam int PIX_MAX = 255;

    typedef struct packed {
        logic       drain;
        logic [7:0] pixel;
    } mat_in_t;

    typedef struct packed {
        logic white;
        logic last_of_frame;
    } mat_out_t;

endpackage

@@ hw/rtl/mean_adaptive_threshold.sv @@
// Adaptive mean threshold over a raster-order grey frame.
// Input channel (s_valid/s_ready/s_data): one request per pixel, or a drain
// request once the frame's pixels are all in. Result channel
// (m_valid/m_ready/m_data): white/black decision plus last_of_frame mark.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// geometry writes restart the frame, mean_offset applies at once.
// The result for a pixel leaves with the request that delivers the pixel
// h rows and h columns later; drain requests flush the tail of the frame.
// A request that yields no result is taken and the block stays idle. One that
// yields a result is worked through the states setup, accumulate, tail, pixel
// and compare, and no new request is taken until its result goes to the output
// register. The accumulate state sums the clipped window, rows*cols pixels
// (at most (2h+1)^2), one pixel per cycle via the single line-store read port.
// The mean compare needs no divider: pix+off >= sum/area is tested as
// (pix+off+1)*area > sum.
// Reset (synchronous, aresetn low) restores default geometry and clears all
// positions; the line store is not cleared, as only pixels of the current
// frame are ever read. A stalled receiver holds the finished result in the
// output register; the next request is still taken and worked on, and only
// its final step waits for the register to free.
module mean_adaptive_threshold
    import mat_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_HALF   = DEF_MAX_HALF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mat_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mat_out_t              m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int SLOTS = 2 * MAX_HALF + 2;
    localparam int SLW   = $clog2(SLOTS);
    localparam int NW    = $clog2(2 * MAX_HALF + 2);
    localparam int AW    = 2 * NW;
    localparam int SUMW  = $clog2(PIX_MAX * (2 * MAX_HALF + 1) * (2 * MAX_HALF + 1) + 1);
    localparam int LW    = $clog2(MAX_HALF * MAX_WIDTH + MAX_HALF + 2);
    localparam int PRW   = 10 + AW;
    localparam int CPW   = (PRW > SUMW) ? PRW : SUMW;
    localparam int MADDR = SLW + CW;
    localparam int RSTW  = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam int RSTH  = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;
    localparam int RSTK  = (RST_HALF > MAX_HALF) ? MAX_HALF : RST_HALF;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_ACC   = 6'b000100,
        ST_TAIL  = 6'b001000,
        ST_PIX   = 6'b010000,
        ST_CMP   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [WW-1:0]      width_reg;
    logic [HW-1:0]      height_reg;
    logic [3:0]         half_reg;
    logic signed [8:0]  offset_reg;
    logic [LW-1:0]      lag_reg;

    // positions
    logic [RW-1:0]  in_row_reg, out_row_reg;
    logic [CW-1:0]  in_col_reg, out_col_reg;
    logic [SLW-1:0] in_slot_reg, out_slot_reg;
    logic           in_done_reg;
    logic [LW-1:0]  pending_reg;

    // window walk
    logic [CW-1:0]   c0_reg, c1_reg, cur_col_reg;
    logic [SLW-1:0]  cur_slot_reg;
    logic [NW-1:0]   rows_left_reg, rows_reg, cols_reg;
    logic            rd_pend_reg;
    logic [SUMW-1:0] sum_reg;
    logic [AW-1:0]   area_reg;
    logic [10:0]     tp_reg;

    logic     m_valid_reg;
    mat_out_t m_data_reg;

    logic cfg_fire, geom_wr, s_fire, emit_done, last_pos;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign geom_wr   = cfg_fire & ((cfg_index == REG_IMAGE_WIDTH) |
                                   (cfg_index == REG_IMAGE_HEIGHT) |
                                   (cfg_index == REG_WINDOW_HALF));
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid & s_ready;
    assign emit_done = (state_reg == ST_CMP) & (~m_valid_reg | m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // clamped register values
    logic [WW-1:0] w_clamped;
    logic [HW-1:0] h_clamped;
    logic [3:0]    k_clamped;

    always_comb begin
        if (cfg_data == '0) begin
            w_clamped = WW'(1);
            h_clamped = HW'(1);
        end else begin
            w_clamped = (int'(cfg_data) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(cfg_data);
            h_clamped = (int'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
        end
        k_clamped = (int'(cfg_data[3:0]) > MAX_HALF) ? 4'(MAX_HALF) : cfg_data[3:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WW'(RSTW);
            height_reg <= HW'(RSTH);
            half_reg   <= 4'(RSTK);
            offset_reg <= RST_OFFSET;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= w_clamped;
                REG_IMAGE_HEIGHT: height_reg <= h_clamped;
                REG_WINDOW_HALF:  half_reg   <= k_clamped;
                REG_MEAN_OFFSET:  offset_reg <= $signed(cfg_data[8:0]);
                default: ;
            endcase
        end
    end

    // lag settles the cycle after a write; the user must send config only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        lag_reg <= LW'(half_reg) * LW'(width_reg) + LW'(half_reg);
    end

    // line store
    logic             mem_we, mem_re;
    logic [MADDR-1:0] mem_waddr, mem_raddr;
    logic [7:0]       mem_rdata;

    assign mem_we    = s_fire & ~in_done_reg & ~s_data.drain;
    assign mem_waddr = {in_slot_reg, in_col_reg};
    assign mem_re    = (state_reg == ST_ACC) | (state_reg == ST_TAIL);
    assign mem_raddr = (state_reg == ST_TAIL) ? {out_slot_reg, out_col_reg}
                                              : {cur_slot_reg, cur_col_reg};

    mat_line_mem #(
        .ADDR_W (MADDR),
        .DATA_W (8)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (s_data.pixel),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // window bounds, clipped at the frame edges
    logic [RW:0]    kr, orow, r0, r1, rhi;
    logic [CW:0]    kc, ocol, c0, c1, chi;
    logic [SLW:0]   dslot, sslot;

    always_comb begin
        kr   = (RW + 1)'(half_reg);
        orow = {1'b0, out_row_reg};
        r0   = (orow >= kr) ? orow - kr : '0;
        rhi  = orow + kr;
        r1   = (rhi < (RW + 1)'(height_reg)) ? rhi : (RW + 1)'(height_reg - 1'b1);
        kc   = (CW + 1)'(half_reg);
        ocol = {1'b0, out_col_reg};
        c0   = (ocol >= kc) ? ocol - kc : '0;
        chi  = ocol + kc;
        c1   = (chi < (CW + 1)'(width_reg)) ? chi : (CW + 1)'(width_reg - 1'b1);
        dslot = (SLW + 1)'(orow - r0);
        if ({1'b0, out_slot_reg} >= dslot) begin
            sslot = {1'b0, out_slot_reg} - dslot;
        end else begin
            sslot = {1'b0, out_slot_reg} + (SLW + 1)'(SLOTS) - dslot;
        end
    end

    assign last_pos = (out_row_reg == RW'(height_reg - 1'b1)) &&
                      (out_col_reg == CW'(width_reg - 1'b1));

    // decision
    logic signed [10:0] t_val;
    logic [PRW-1:0]     prod;
    logic               white_bit;

    always_comb begin
        t_val     = $signed({3'b000, mem_rdata}) + $signed({{2{offset_reg[8]}}, offset_reg})
                    + 11'sd1;
        prod      = PRW'(tp_reg[9:0]) * PRW'(area_reg);
        white_bit = ~tp_reg[10] && (tp_reg != '0) && (CPW'(prod) > CPW'(sum_reg));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (in_done_reg) begin
                        state_next = ST_SETUP;
                    end else if (!s_data.drain && (pending_reg >= lag_reg)) begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: state_next = ST_ACC;
            ST_ACC: begin
                if ((rows_left_reg == '0) && (cur_col_reg == c1_reg)) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: state_next = ST_PIX;
            ST_PIX:  state_next = ST_CMP;
            ST_CMP: begin
                if (emit_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else if (geom_wr) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // positions and pending count
    always_ff @(posedge aclk) begin
        if (!aresetn || geom_wr || (emit_done && last_pos)) begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            in_done_reg  <= 1'b0;
            pending_reg  <= '0;
        end else begin
            if (mem_we) begin
                pending_reg <= pending_reg + 1'b1;
                if (in_col_reg == CW'(width_reg - 1'b1)) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + 1'b1;
                    in_slot_reg <= (in_slot_reg == SLW'(SLOTS - 1)) ? '0 : in_slot_reg + 1'b1;
                    if (in_row_reg == RW'(height_reg - 1'b1)) begin
                        in_done_reg <= 1'b1;
                    end
                end else begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
            end else if (emit_done) begin
                pending_reg <= pending_reg - 1'b1;
                if (out_col_reg == CW'(width_reg - 1'b1)) begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + 1'b1;
                    out_slot_reg <= (out_slot_reg == SLW'(SLOTS - 1)) ? '0
                                                                    : out_slot_reg + 1'b1;
                end else begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
        end
    end

    // window walk and sum
    always_ff @(posedge aclk) begin
        rd_pend_reg <= (state_reg == ST_ACC);
        case (state_reg)
            ST_SETUP: begin
                sum_reg       <= '0;
                c0_reg        <= CW'(c0);
                c1_reg        <= CW'(c1);
                cur_col_reg   <= CW'(c0);
                cur_slot_reg  <= SLW'(sslot);
                rows_left_reg <= NW'(r1 - r0);
                rows_reg      <= NW'(r1 - r0 + 1'b1);
                cols_reg      <= NW'(c1 - c0 + 1'b1);
            end
            ST_ACC: begin
                if (rd_pend_reg) begin
                    sum_reg <= sum_reg + SUMW'(mem_rdata);
                end
                if (cur_col_reg == c1_reg) begin
                    cur_col_reg   <= c0_reg;
                    rows_left_reg <= rows_left_reg - 1'b1;
                    cur_slot_reg  <= (cur_slot_reg == SLW'(SLOTS - 1)) ? '0
                                                                       : cur_slot_reg + 1'b1;
                end else begin
                    cur_col_reg <= cur_col_reg + 1'b1;
                end
            end
            ST_TAIL: begin
                sum_reg  <= sum_reg + SUMW'(mem_rdata);
                area_reg <= AW'(rows_reg) * AW'(cols_reg);
            end
            ST_PIX: begin
                tp_reg <= t_val;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_done) begin
            m_data_reg.white         <= white_bit;
            m_data_reg.last_of_frame <= last_pos;
        end
    end

endmodule

@@ hw/rtl/mat_line_mem.sv @@
module mat_line_mem
    import mat_pkg::*;
#(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
